FILE: hdl/rsh_pkg.sv
package rsh_pkg;

  localparam int HIST_DEPTH = 16;
  localparam int HIST_IDX_W = $clog2(HIST_DEPTH);
  localparam int HIST_CNT_W = $clog2(HIST_DEPTH + 1);
  localparam int SEQ_W      = 32;
  localparam int SIZE_W     = 5;

  localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(16);

  typedef enum logic [1:0] {
    VERDICT_ACCEPT    = 2'd0,
    VERDICT_DUPLICATE = 2'd1,
    VERDICT_TOO_OLD   = 2'd2
  } verdict_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DECIDE
  } state_t;

  // size register clamped to 1..HIST_DEPTH
  function automatic logic [HIST_CNT_W-1:0] eff_size(input logic [SIZE_W-1:0] size);
    logic [HIST_CNT_W-1:0] s;
    if (size == '0) begin
      s = HIST_CNT_W'(1);
    end else if (32'(size) > HIST_DEPTH) begin
      s = HIST_CNT_W'(HIST_DEPTH);
    end else begin
      s = HIST_CNT_W'(size);
    end
    return s;
  endfunction

endpackage

FILE: hdl/rsh_hist_mem.sv
module rsh_hist_mem #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 32,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: hdl/replay_sequence_history_check.sv
// Anti-replay check on received sequence numbers. Each word on the in_ channel
// yields one verdict word on the out_ channel: accepted, duplicate, or (with a full
// history) older than the smallest number held. The history lives in a 16 x 32
// single-read-port RAM; an item scans the filled entries one per cycle (duplicate
// match and running minimum), then commits at most one write. From acceptance to a
// loaded verdict an item goes through one RAM read per filled entry, the registered
// read data and the decide state. A new word is taken only when the previous one
// has committed; the output register lets it enter while the last verdict is still
// waiting. cfg_wr_data sets the history size (0 acts as 1, above 16 acts as 16);
// write it only while the block is idle.
module replay_sequence_history_check
  import rsh_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [SEQ_W-1:0]     in_sequence_number,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [1:0]           out_verdict,
  input  logic                 cfg_wr_en,
  input  logic [SIZE_W-1:0]    cfg_wr_data
);

  state_t state_r, state_nxt;

  logic [SIZE_W-1:0]     size_r;
  logic [HIST_CNT_W-1:0] fill_r;
  logic [SEQ_W-1:0]      seq_r;
  logic [HIST_CNT_W-1:0] issue_cnt_r;
  logic                  pend_r;
  logic [HIST_IDX_W-1:0] pend_idx_r;
  logic                  dup_r;
  logic [SEQ_W-1:0]      min_r;
  logic [HIST_IDX_W-1:0] slot_r;
  logic                  out_valid_r;
  verdict_t              out_verdict_r;

  logic                  in_acc;
  logic                  out_free;
  logic                  rd_en;
  logic                  commit;
  logic                  scan_done;
  logic [SEQ_W-1:0]      rd_data;
  logic                  append;
  verdict_t              verdict;
  logic                  mem_we;
  logic [HIST_IDX_W-1:0] mem_waddr;

  assign in_acc   = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;
  assign scan_done = (issue_cnt_r == fill_r) && !pend_r;

  rsh_hist_mem #(
    .DEPTH (HIST_DEPTH),
    .WIDTH (SEQ_W)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (seq_r),
    .re    (rd_en),
    .raddr (issue_cnt_r[HIST_IDX_W-1:0]),
    .rdata (rd_data)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:   if (in_valid) state_nxt = ST_SCAN;
      ST_SCAN:   if (scan_done) state_nxt = ST_DECIDE;
      ST_DECIDE: if (out_free) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    in_ready = 1'b0;
    rd_en    = 1'b0;
    commit   = 1'b0;
    unique case (state_r)
      ST_IDLE:   in_ready = 1'b1;
      ST_SCAN:   rd_en = (issue_cnt_r < fill_r);
      ST_DECIDE: commit = out_free;
      default:   ;
    endcase
  end

  // verdict; min_r only matters in full mode where fill_r >= 1
  always_comb begin
    append = !dup_r && (fill_r < eff_size(size_r));
    priority if (dup_r) begin
      verdict = VERDICT_DUPLICATE;
    end else if (append) begin
      verdict = VERDICT_ACCEPT;
    end else if (seq_r < min_r) begin
      verdict = VERDICT_TOO_OLD;
    end else begin
      verdict = VERDICT_ACCEPT;
    end
    mem_we    = commit && (verdict == VERDICT_ACCEPT);
    mem_waddr = append ? fill_r[HIST_IDX_W-1:0] : slot_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      size_r      <= SIZE_RESET;
      fill_r      <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      pend_r  <= rd_en;
      if (cfg_wr_en) begin
        size_r <= cfg_wr_data;
      end
      if (commit && append) begin
        fill_r <= fill_r + HIST_CNT_W'(1);
      end
      if (commit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // scan datapath
  always_ff @(posedge clk) begin
    if (in_acc) begin
      seq_r       <= in_sequence_number;
      issue_cnt_r <= '0;
      dup_r       <= 1'b0;
      min_r       <= '1;
      slot_r      <= '0;
    end else begin
      if (rd_en) begin
        issue_cnt_r <= issue_cnt_r + HIST_CNT_W'(1);
      end
      if (pend_r) begin
        if (rd_data == seq_r) begin
          dup_r <= 1'b1;
        end
        // <= keeps the highest index on ties
        if (rd_data <= min_r) begin
          min_r  <= rd_data;
          slot_r <= pend_idx_r;
        end
      end
    end
    pend_idx_r <= issue_cnt_r[HIST_IDX_W-1:0];
    if (commit) begin
      out_verdict_r <= verdict;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_verdict = out_verdict_r;

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(fill_r) <= HIST_DEPTH)
    else $error("fill count beyond history depth");

  a_fill_step: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && (fill_r != $past(fill_r)) |-> fill_r == $past(fill_r) + HIST_CNT_W'(1))
    else $error("fill count moved by other than one");

  a_verdict_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_verdict != 2'd3)
    else $error("illegal verdict code");

  a_no_read_on_write: assert property (@(posedge clk) disable iff (!rst_n)
    !(mem_we && rd_en))
    else $error("history read and write overlap");

  a_out_load: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(state_r == ST_DECIDE))
    else $error("verdict loaded outside decide");

endmodule

FILE: tb/sv/rsh_verdict_checker.sv
`timescale 1ns / 1ps

// Watches both channels and the size register, keeps its own copy of the
// sequence history and checks every verdict word in order.
module rsh_verdict_checker
  import rsh_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_ready,
  input  logic [SEQ_W-1:0]  in_sequence_number,
  input  logic              out_valid,
  input  logic              out_ready,
  input  logic [1:0]        out_verdict,
  input  logic              cfg_wr_en,
  input  logic [SIZE_W-1:0] cfg_wr_data,
  output int                fail_count,
  output int                pending_count
);

  logic [SEQ_W-1:0]  hist_mem [HIST_DEPTH];
  int unsigned       hist_fill;
  logic [SIZE_W-1:0] hist_size;
  verdict_t          verdict_q[$];
  verdict_t          want;

  initial begin
    fail_count    = 0;
    pending_count = 0;
  end

  // 0 behaves as 1, anything past the depth as the depth
  function automatic int unsigned size_in_use();
    int unsigned s;
    s = hist_size;
    if (s < 1) begin
      s = 1;
    end
    if (s > HIST_DEPTH) begin
      s = HIST_DEPTH;
    end
    return s;
  endfunction

  function automatic verdict_t judge_sequence(input logic [SEQ_W-1:0] seq);
    int unsigned      slot;
    logic [SEQ_W-1:0] low;
    for (int i = 0; i < hist_fill; i++) begin
      if (hist_mem[i] == seq) begin
        return VERDICT_DUPLICATE;
      end
    end
    if (hist_fill < size_in_use()) begin
      hist_mem[hist_fill] = seq;
      hist_fill++;
      return VERDICT_ACCEPT;
    end
    // full: replace the smallest entry, last index on a tie
    low  = '1;
    slot = 0;
    for (int i = 0; i < hist_fill; i++) begin
      if (hist_mem[i] <= low) begin
        low  = hist_mem[i];
        slot = i;
      end
    end
    if (seq < low) begin
      return VERDICT_TOO_OLD;
    end
    hist_mem[slot] = seq;
    return VERDICT_ACCEPT;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("[%0t] MISMATCH: %s", $time, msg);
    fail_count++;
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      hist_fill = 0;
      hist_size = SIZE_RESET;
      verdict_q.delete();
    end else begin
      if (cfg_wr_en) begin
        hist_size = cfg_wr_data;
      end
      if (in_valid && in_ready) begin
        verdict_q.push_back(judge_sequence(in_sequence_number));
      end
      if (out_valid && out_ready) begin
        if (verdict_q.size() == 0) begin
          report_mismatch($sformatf("verdict word %0d with none expected", out_verdict));
        end else begin
          want = verdict_q.pop_front();
          if (out_verdict !== want) begin
            report_mismatch($sformatf("verdict %0d, expected %s (%0d)",
                                      out_verdict, want.name(), want));
          end
        end
      end
    end
    pending_count <= verdict_q.size();
  end

endmodule

FILE: tb/sv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import rsh_pkg::*;

  localparam int CYCLE_LIMIT   = 400000;
  localparam int SETTLE_CYCLES = 40;
  localparam int PHASE_ITEMS   = 145;
  localparam int PHASES        = 10;

  logic              clk                = 1'b0;
  logic              rst_n              = 1'b0;
  logic              in_valid           = 1'b0;
  logic              in_ready;
  logic [SEQ_W-1:0]  in_sequence_number = '0;
  logic              out_valid;
  logic              out_ready          = 1'b0;
  logic [1:0]        out_verdict;
  logic              cfg_wr_en          = 1'b0;
  logic [SIZE_W-1:0] cfg_wr_data        = '0;

  int               fail_count;
  int               pending_count;
  int unsigned      cycle_count = 0;
  bit               no_idle     = 1'b0;
  logic [SEQ_W-1:0] seq_base    = '0;
  logic [SEQ_W-1:0] seq_top     = '0;
  logic [SEQ_W-1:0] recent_q[$];

  replay_sequence_history_check dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_sequence_number (in_sequence_number),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_verdict        (out_verdict),
    .cfg_wr_en          (cfg_wr_en),
    .cfg_wr_data        (cfg_wr_data)
  );

  rsh_verdict_checker u_checker (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_sequence_number (in_sequence_number),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_verdict        (out_verdict),
    .cfg_wr_en          (cfg_wr_en),
    .cfg_wr_data        (cfg_wr_data),
    .fail_count         (fail_count),
    .pending_count      (pending_count)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // one word on the input channel; returns at the accepting edge
  task automatic send_word(input logic [SEQ_W-1:0] seq);
    int unsigned gap;
    gap = no_idle ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid           <= 1'b1;
    in_sequence_number <= seq;
    do @(posedge clk); while (!in_ready);
    recent_q.push_back(seq);
    if (recent_q.size() > 24) begin
      void'(recent_q.pop_front());
    end
    // near-max extremes would drag the base up to a wrap
    if (seq < 32'hFFFF_FF00 && seq > seq_top) begin
      seq_top = seq;
    end
  endtask

  task automatic write_size(input logic [SIZE_W-1:0] value);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  // stop sending, wait for every verdict, then let the block settle
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_count != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // mostly a rising stream with repeats and stragglers mixed in
  function automatic logic [SEQ_W-1:0] next_sequence();
    int unsigned      pick;
    logic [SEQ_W-1:0] v;
    pick = $urandom_range(0, 99);
    if (pick < 50) begin
      seq_base = seq_base + $urandom_range(1, 6);
      v = seq_base;
    end else if (pick < 70 && recent_q.size() > 0) begin
      v = recent_q[$urandom_range(0, recent_q.size() - 1)];
    end else if (pick < 88) begin
      v = seq_base - $urandom_range(0, 48);
    end else if (pick < 93) begin
      v = $urandom;
    end else if (pick < 98) begin
      v = $urandom_range(0, 3);
    end else begin
      v = '1 - $urandom_range(0, 3);
    end
    return v;
  endfunction

  initial begin
    int unsigned stall;
    do @(posedge clk); while (!rst_n);
    forever begin
      stall = no_idle ? 0 : $urandom_range(0, 5);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  initial begin
    logic [SIZE_W-1:0] phase_size [PHASES];
    phase_size = '{5'd16, 5'd1, 5'd0, 5'd31, 5'd17, 5'd5, 5'd2, 5'd12,
                   SIZE_W'($urandom_range(2, 15)), 5'd16};

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // size 0 acts as one entry: accept, duplicate, too old, replace
    write_size(5'd0);
    send_word(32'h0000_0010);
    send_word(32'h0000_0010);
    send_word(32'h0000_0005);
    send_word(32'h0000_0020);
    drain();

    // raised while full: appending resumes
    write_size(5'd3);
    send_word(32'h0000_0000);
    send_word(32'hFFFF_FFFF);
    send_word(32'h0000_0000);
    send_word(32'h0000_0030);
    send_word(32'h0000_0001);
    drain();

    // oversized setting saturates to the full depth
    write_size(5'd31);
    send_word(32'h0000_0040);
    send_word(32'h0000_0041);
    send_word(32'h0000_0040);
    send_word(32'hFFFF_FFFF);
    drain();

    write_size(5'd17);
    send_word(32'h7FFF_FFFF);
    send_word(32'h8000_0000);
    send_word(32'h5555_5555);
    send_word(32'hAAAA_AAAA);
    send_word(32'h0000_0002);
    drain();

    for (int p = 0; p < PHASES; p++) begin
      write_size(phase_size[p]);
      seq_base = seq_top + $urandom_range(1, 500);
      no_idle  = (p % 4 == 3);
      repeat (PHASE_ITEMS) send_word(next_sequence());
      drain();
    end

    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
